// File: design/cme_pkg.sv
// Shared types and constants of the clamp, median and moving-average conditioner.
package cme_pkg;

   // Field widths of the sample path.
   localparam int RAW_W    = 16;
   localparam int SAMPLE_W = 10;
   localparam int WEIGHT_W = 9;
   localparam int FRAC_W   = 8;
   localparam int AVG_W    = SAMPLE_W + FRAC_W;
   localparam int PROD_W   = WEIGHT_W + AVG_W;

   // Default window depth.
   localparam int WINDOW_DEFAULT = 5;

   // Control and status register port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_WEIGHT = 2'd2;

   // Register values after reset.
   localparam logic [SAMPLE_W-1:0] CLAMP_LOW_RESET  = 10'd0;
   localparam logic [SAMPLE_W-1:0] CLAMP_HIGH_RESET = 10'd1023;
   localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RESET = 9'd77;

   // A weight of one in Q1.8, and the largest weight used.
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

   // Half of one LSB of the integer part, for rounding.
   localparam logic [AVG_W:0] ROUND_HALF = 19'd128;

   // Bias that turns a truncating shift into a rounding-up shift.
   localparam logic [PROD_W:0] FLOOR_BIAS = 28'd255;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_UPD,
      ST_DONE
   } state_type;

   // Result of ranking one window entry against the filled window.
   typedef struct packed {
      logic                hit;
      logic [SAMPLE_W-1:0] value;
   } scan_status_type;

   // Steps of the moving-average unit.
   typedef struct packed {
      logic mul;
      logic upd;
   } ema_ctrl_type;

endpackage

// File: design/cme_window.sv
// Circular sample window and the rank unit that finds its median one entry per cycle.
module cme_window #(
   parameter int WINDOW = cme_pkg::WINDOW_DEFAULT,
   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [cme_pkg::SAMPLE_W-1:0]       wr_data,
   input  logic [IDX_W-1:0]                   cand_idx,
   output cme_pkg::scan_status_type           status
);
   import cme_pkg::*;

   localparam int CNT_W = $clog2(WINDOW + 1);

   logic [SAMPLE_W-1:0] win_ff [WINDOW];
   logic [IDX_W-1:0]    slot_ff;
   logic [IDX_W-1:0]    slot_in;
   logic                full_ff;
   logic                full_in;
   logic [CNT_W-1:0]    count;
   logic [CNT_W-1:0]    mid;
   logic [CNT_W-1:0]    less;
   logic [CNT_W-1:0]    equal;
   logic [CNT_W:0]      upper;
   logic [SAMPLE_W-1:0] cand;

   // Next write slot; the window counts as full once the slot wraps.
   always_comb begin
      slot_in = slot_ff;
      full_in = full_ff;
      if (wr_en) begin
         if (slot_ff == IDX_W'(WINDOW - 1)) begin
            slot_in = '0;
            full_in = 1'b1;
         end else begin
            slot_in = slot_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         full_ff <= full_in;
      end
   end

   // Window storage has no reset; entries beyond the fill count are masked below.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_ff[slot_ff] <= wr_data;
      end
   end

   // Number of filled entries and the rank that the median holds among them.
   always_comb begin
      if (full_ff || (slot_ff == '0)) begin
         count = CNT_W'(WINDOW);
      end else begin
         count = CNT_W'(slot_ff);
      end
      mid = count >> 1;
   end

   // Compare the candidate against every filled entry at once.
   always_comb begin
      cand  = win_ff[cand_idx];
      less  = '0;
      equal = '0;
      for (int j = 0; j < WINDOW; j++) begin
         if (CNT_W'(j) < count) begin
            if (win_ff[j] < cand) begin
               less = less + CNT_W'(1);
            end
            if (win_ff[j] == cand) begin
               equal = equal + CNT_W'(1);
            end
         end
      end
      upper = {1'b0, less} + {1'b0, equal};
   end

   // The candidate is the median when its run of equal values covers the middle rank.
   assign status.hit   = (less <= mid) && ({1'b0, mid} < upper);
   assign status.value = cand;

endmodule

// File: design/cme_ema.sv
// Exponential moving average in Q10.8: one multiply step and one update step per sample.
module cme_ema (
   input  logic                              clock,
   input  logic                              reset,
   input  cme_pkg::ema_ctrl_type             ctrl,
   input  logic [cme_pkg::SAMPLE_W-1:0]      median,
   input  logic [cme_pkg::WEIGHT_W-1:0]      weight,
   output logic [cme_pkg::AVG_W-1:0]         average
);
   import cme_pkg::*;

   logic [AVG_W-1:0]    avg_ff;
   logic [AVG_W-1:0]    avg_in;
   logic                started_ff;
   logic                started_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic                up_ff;
   logic                up_in;
   logic [WEIGHT_W-1:0] weight_sat;
   logic [AVG_W-1:0]    target;
   logic [AVG_W-1:0]    diff;
   logic [PROD_W:0]     prod_biased;
   logic [AVG_W-1:0]    step;

   // Weights above one are held at one.
   assign weight_sat = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
   assign target     = {median, FRAC_W'(0)};

   // Multiply step: weight times the distance between target and average.
   always_comb begin
      up_in   = (target >= avg_ff);
      diff    = up_in ? (target - avg_ff) : (avg_ff - target);
      prod_in = PROD_W'(weight_sat) * PROD_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff <= prod_in;
         up_ff   <= up_in;
      end
   end

   // Update step: the downward step rounds its magnitude up so the result floors.
   always_comb begin
      prod_biased = {1'b0, prod_ff} + FLOOR_BIAS;
      if (up_ff) begin
         step = prod_ff[FRAC_W +: AVG_W];
      end else begin
         step = prod_biased[FRAC_W +: AVG_W];
      end
      avg_in     = avg_ff;
      started_in = started_ff;
      if (ctrl.upd) begin
         started_in = 1'b1;
         if (!started_ff) begin
            avg_in = target;
         end else if (up_ff) begin
            avg_in = avg_ff + step;
         end else begin
            avg_in = avg_ff - step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         avg_ff     <= avg_in;
         started_ff <= started_in;
      end
   end

   assign average = avg_ff;

endmodule

// File: design/clamp_median_ema_conditioner_unit.sv
// Top level of the clamp, median and moving-average sample conditioner.
// Each request carries one signed raw sample. It is clamped to clamp_low..clamp_high and
// written into a circular window of WINDOW samples; the median of the filled entries
// (upper median for an even fill) feeds a moving average in unsigned Q10.8. The first
// median loads the average; later ones move it by ema_weight/256 of the gap. After acceptance
// the rank unit tests one window entry per cycle, in index order, until it finds the median;
// then the average takes a multiply step and an update step, and the sequencer loads the
// output register once that register is free. A finished response waits in the output
// register while the next request is accepted; the block takes a new request only after
// the previous one has left the sequencer. Register writes are always accepted and are
// meant for idle times.
module clamp_median_ema_conditioner_unit #(
   parameter int WINDOW = cme_pkg::WINDOW_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [cme_pkg::RAW_W-1:0]   req_raw_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cme_pkg::SAMPLE_W-1:0]       rsp_clamped_sample,
   output logic [cme_pkg::SAMPLE_W-1:0]       rsp_median_sample,
   output logic [cme_pkg::AVG_W-1:0]          rsp_average_fixed,
   output logic [cme_pkg::SAMPLE_W-1:0]       rsp_average_rounded,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cme_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cme_pkg::CSR_DATA_W-1:0]     csr_data
);
   import cme_pkg::*;

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   state_type           state_ff;
   state_type           state_in;
   logic [IDX_W-1:0]    cand_ff;
   logic [IDX_W-1:0]    cand_in;
   logic [SAMPLE_W-1:0] clamp_low_ff;
   logic [SAMPLE_W-1:0] clamp_high_ff;
   logic [WEIGHT_W-1:0] ema_weight_ff;
   logic [SAMPLE_W-1:0] clamped;
   logic [SAMPLE_W-1:0] clamped_ff;
   logic [SAMPLE_W-1:0] median_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_clamped_ff;
   logic [SAMPLE_W-1:0] rsp_median_ff;
   logic [AVG_W-1:0]    rsp_average_ff;
   logic [SAMPLE_W-1:0] rsp_rounded_ff;
   logic [AVG_W:0]      avg_round;
   logic [AVG_W-1:0]    average;
   logic                win_wr;
   logic                median_load;
   logic                out_load;
   scan_status_type     scan;
   ema_ctrl_type        ema_ctrl;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_low_ff  <= CLAMP_LOW_RESET;
         clamp_high_ff <= CLAMP_HIGH_RESET;
         ema_weight_ff <= EMA_WEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CLAMP_LOW:  clamp_low_ff  <= csr_data;
            CSR_CLAMP_HIGH: clamp_high_ff <= csr_data;
            CSR_EMA_WEIGHT: ema_weight_ff <= csr_data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the raw sample; the low bound is tested first.
   always_comb begin
      if (req_raw_sample < $signed({{(RAW_W - SAMPLE_W){1'b0}}, clamp_low_ff})) begin
         clamped = clamp_low_ff;
      end else if (req_raw_sample > $signed({{(RAW_W - SAMPLE_W){1'b0}}, clamp_high_ff}))
      begin
         clamped = clamp_high_ff;
      end else begin
         clamped = req_raw_sample[SAMPLE_W-1:0];
      end
   end

   // Window storage and rank unit.
   cme_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (win_wr),
      .wr_data  (clamped),
      .cand_idx (cand_ff),
      .status   (scan)
   );

   // Moving-average unit.
   cme_ema u_ema (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ema_ctrl),
      .median  (median_ff),
      .weight  (ema_weight_ff),
      .average (average)
   );

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cand_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cand_ff  <= cand_in;
      end
   end

   // Sequencer: accept, scan the window for the median, update the average, hand off.
   always_comb begin
      state_in    = state_ff;
      cand_in     = cand_ff;
      req_ready   = 1'b0;
      win_wr      = 1'b0;
      median_load = 1'b0;
      out_load    = 1'b0;
      ema_ctrl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               win_wr   = 1'b1;
               cand_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan.hit) begin
               median_load = 1'b1;
               state_in    = ST_MUL;
            end else begin
               cand_in = cand_ff + IDX_W'(1);
            end
         end
         ST_MUL: begin
            ema_ctrl.mul = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            ema_ctrl.upd = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Working values of the request in flight.
   always_ff @(posedge clock) begin
      if (win_wr) begin
         clamped_ff <= clamped;
      end
      if (median_load) begin
         median_ff <= scan.value;
      end
   end

   // Round half up to the integer part.
   assign avg_round = {1'b0, average} + ROUND_HALF;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_clamped_ff <= clamped_ff;
         rsp_median_ff  <= median_ff;
         rsp_average_ff <= average;
         rsp_rounded_ff <= avg_round[FRAC_W +: SAMPLE_W];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_clamped_sample  = rsp_clamped_ff;
   assign rsp_median_sample   = rsp_median_ff;
   assign rsp_average_fixed   = rsp_average_ff;
   assign rsp_average_rounded = rsp_rounded_ff;

endmodule

// File: design/cme_checker.sv
// Port-level checks of the conditioner, bound to its top level.
module cme_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [cme_pkg::SAMPLE_W-1:0]       rsp_clamped_sample,
   input logic [cme_pkg::SAMPLE_W-1:0]       rsp_median_sample,
   input logic [cme_pkg::AVG_W-1:0]          rsp_average_fixed,
   input logic [cme_pkg::SAMPLE_W-1:0]       rsp_average_rounded
);
   import cme_pkg::*;

   logic [AVG_W:0] avg_round;

   assign avg_round = {1'b0, rsp_average_fixed} + ROUND_HALF;

   // A stalled response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average_fixed)
         && $stable(rsp_median_sample) && $stable(rsp_clamped_sample))
      else $error("stalled response changed");

   // While a response is valid, the rounded average matches the fixed-point average.
   a_round: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_average_rounded == avg_round[FRAC_W +: SAMPLE_W])
      else $error("rounded average does not match fixed average");

   // The block is busy in the cycle after it takes a request.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in work");

   // No response is pending right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind clamp_median_ema_conditioner_unit cme_checker u_cme_checker (.*);
